FILE: hdl/cmkx_pkg.sv
package cmkx_pkg;

    localparam int TS_DEPTH = 2048;

    typedef enum logic [2:0] {
        CMD_CPU_WRITE = 3'd0,
        CMD_CPU_READ  = 3'd1,
        CMD_CPU_MAP   = 3'd2,
        CMD_CPU_TICK  = 3'd3,
        CMD_NT_READ   = 3'd4,
        CMD_NT_WRITE  = 3'd5,
        CMD_CHR_READ  = 3'd6,
        CMD_UNUSED    = 3'd7
    } t_cmd;

    localparam logic [3:0] TGT_NONE     = 4'd0;
    localparam logic [3:0] TGT_CHR_RAM  = 4'd1;
    localparam logic [3:0] TGT_CHR_ROM  = 4'd2;
    localparam logic [3:0] TGT_CONST    = 4'd3;
    localparam logic [3:0] TGT_WRAM     = 4'd4;
    localparam logic [3:0] TGT_BRAM     = 4'd5;
    localparam logic [3:0] TGT_PRG      = 4'd6;
    localparam logic [3:0] TGT_CIRAM    = 4'd7;
    localparam logic [3:0] TGT_INTERNAL = 4'd8;

    // Register pages (address bits 15:8).
    localparam logic [7:0] PG_WIN0    = 8'hD0;
    localparam logic [7:0] PG_WIN1    = 8'hD1;
    localparam logic [7:0] PG_PRG0    = 8'hD2;
    localparam logic [7:0] PG_PRG1    = 8'hD3;
    localparam logic [7:0] PG_PRG2    = 8'hD4;
    localparam logic [7:0] PG_CHR     = 8'hD5;
    localparam logic [7:0] PG_IRQ_LO  = 8'hD6;
    localparam logic [7:0] PG_IRQ_HI  = 8'hD7;
    localparam logic [7:0] PG_IRQ_ACK = 8'hD8;
    localparam logic [7:0] PG_IRQ_CTL = 8'hD9;
    localparam logic [7:0] PG_MIRROR  = 8'hDA;
    localparam logic [7:0] PG_XPOS    = 8'hDB;
    localparam logic [7:0] PG_XCOL    = 8'hDC;
    localparam logic [7:0] PG_XROW    = 8'hDD;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        read_valid;
        logic        irq_line;
        logic [3:0]  target;
        logic [19:0] target_address;
        logic        target_write;
    } t_out_item;

    function automatic logic [7:0] xlate_lookup(input logic [1:0] col, input logic [2:0] row);
        logic [7:0] t;
        t = 8'h00;
        case (col)
            2'd1: begin
                case (row)
                    3'd2: t = 8'h40;
                    3'd3: t = 8'h10;
                    3'd4: t = 8'h28;
                    3'd6: t = 8'h18;
                    3'd7: t = 8'h30;
                    default: t = 8'h00;
                endcase
            end
            2'd2: begin
                case (row)
                    3'd2: t = 8'h48;
                    3'd3: t = 8'h18;
                    3'd4: t = 8'h30;
                    3'd5: t = 8'h08;
                    3'd6: t = 8'h20;
                    3'd7: t = 8'h38;
                    default: t = 8'h00;
                endcase
            end
            2'd3: begin
                case (row)
                    3'd2: t = 8'h80;
                    3'd3: t = 8'h20;
                    3'd4: t = 8'h38;
                    3'd5: t = 8'h10;
                    3'd6: t = 8'h28;
                    3'd7: t = 8'hB0;
                    default: t = 8'h00;
                endcase
            end
            default: t = 8'h00;
        endcase
        return t;
    endfunction

    // Program bank value from a bank register write.
    function automatic logic [6:0] prg_bank_of(input logic [7:0] v);
        logic [6:0] b;
        if (v[6]) begin
            b = {1'b0, v[5:0]} + 7'h10;
        end else begin
            b = {3'b000, v[3:0]};
        end
        return b;
    endfunction

    // Tile store index: mirroring picks A10 or A11 as the page bit.
    function automatic logic [10:0] nt_index(input logic [15:0] a, input logic mirror);
        return {(mirror ? a[11] : a[10]), a[9:0]};
    endfunction

endpackage

FILE: hdl/cartridge_mapper_with_kanji_xlate_top.sv
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+-----------------------------
// in       | to block  | i_in_valid / o_in_stall | i_in_item  (t_in_item)
// out      | from block| o_out_valid/ i_out_stall| o_out_item (t_out_item)
//
// Every transfer on the in channel yields exactly one transfer on the out channel.
// The tile store read issues at the input transfer, and the mapper stage uses its
// data while holding the item and then loads the output register. While the output
// is not stalled, one item per cycle is sustained: the tile store has a write port
// for the mapper stage and a separate registered read port for the incoming item,
// and a bypass covers a write and a read of the same entry in one cycle. Reset is
// synchronous and active low; the tile store itself is not cleared. A stalled
// output register holds the mapper stage, which then stalls the input.
module cartridge_mapper_with_kanji_xlate_top
    import cmkx_pkg::*;
#(
    parameter int TILE_STORE_DEPTH = TS_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int IDX_W = $clog2(TILE_STORE_DEPTH);

    // Tile store: one write port, one registered read port.
    logic [7:0] mem [TILE_STORE_DEPTH];
    logic [7:0] r_rd_data;
    logic       r_fwd;
    logic [7:0] r_fwd_data;

    // Mapper stage holding the item whose tile store data is ready.
    logic     r_s1_valid;
    t_in_item r_s1_item;

    // Architectural state.
    logic [7:0]  r_tile_value;
    logic [1:0]  r_irq_en;
    logic [15:0] r_irq_reload;
    logic [15:0] r_irq_count;
    logic        r_irq_pending;
    logic [6:0]  r_prg_bank [3];
    logic [1:0]  r_win_sel [2];
    logic        r_chr_half;
    logic        r_mirror;
    logic        r_store_tgt;
    logic [2:0]  r_xpos;
    logic [7:0]  r_xcol;
    logic [7:0]  r_xrow;

    logic [7:0]  n_tile_value;
    logic [1:0]  n_irq_en;
    logic [15:0] n_irq_reload;
    logic [15:0] n_irq_count;
    logic        n_irq_pending;
    logic [6:0]  n_prg_bank [3];
    logic [1:0]  n_win_sel [2];
    logic        n_chr_half;
    logic        n_mirror;
    logic        n_store_tgt;
    logic [2:0]  n_xpos;
    logic [7:0]  n_xcol;
    logic [7:0]  n_xrow;

    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;

    logic             out_free;
    logic             s1_adv;
    logic             in_acc;
    logic             mirror_eff;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] s1_idx;
    logic [10:0]      rd_full;
    logic [10:0]      s1_full;
    logic [7:0]       mem_q;
    logic             mem_we;
    logic [7:0]       xl_t;
    logic [7:0]       xl_hi;
    logic [7:0]       xl_lo;
    logic [1:0]       win;
    logic [7:0]       page;
    t_cmd             s1_cmd;

    // The output register frees when empty or when its transfer completes now.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign s1_cmd = t_cmd'(r_s1_item.command);
    assign page   = r_s1_item.address[15:8];

    // The read issues with the mirroring that the mapper stage item leaves
    // behind, so a mirroring write right ahead of a nametable read is honored.
    assign mirror_eff = r_s1_valid ? n_mirror : r_mirror;
    assign rd_full    = nt_index(i_in_item.address, mirror_eff);
    assign rd_idx     = rd_full[IDX_W-1:0];
    assign s1_full    = nt_index(r_s1_item.address, r_mirror);
    assign s1_idx     = s1_full[IDX_W-1:0];

    // A write by the older item in the same cycle bypasses the read port.
    assign mem_q = r_fwd ? r_fwd_data : r_rd_data;

    assign mem_we = s1_adv && (s1_cmd == CMD_NT_WRITE) && r_store_tgt;

    // Kanji translation of the current column, row and position.
    always_comb begin
        xl_t  = xlate_lookup(r_xcol[6:5], r_xrow[6:4]);
        xl_hi = 8'h40 | {2'b00, xl_t[5:0]} | {5'b00000, r_xrow[3:1]} | {r_xpos[2], 7'b0};
        if (xl_t[6]) begin
            xl_hi[2] = 1'b0;
        end else if (xl_t[7]) begin
            xl_hi[2] = 1'b1;
        end
        xl_lo = {r_xrow[0], r_xcol[4:0], r_xpos[1:0]};
    end

    // Mapper stage: result and next state of the item in it.
    always_comb begin
        n_tile_value  = r_tile_value;
        n_irq_en      = r_irq_en;
        n_irq_reload  = r_irq_reload;
        n_irq_count   = r_irq_count;
        n_irq_pending = r_irq_pending;
        n_prg_bank    = r_prg_bank;
        n_win_sel     = r_win_sel;
        n_chr_half    = r_chr_half;
        n_mirror      = r_mirror;
        n_store_tgt   = r_store_tgt;
        n_xpos        = r_xpos;
        n_xcol        = r_xcol;
        n_xrow        = r_xrow;
        win           = r_win_sel[r_s1_item.address[12]];
        n_out_item    = '0;

        unique case (s1_cmd)
            CMD_CPU_WRITE: begin
                unique case (page)
                    PG_WIN0, PG_WIN1: begin
                        n_win_sel[page[0]] = {r_s1_item.write_data[3], r_s1_item.write_data[0]};
                    end
                    PG_PRG0: n_prg_bank[0] = prg_bank_of(r_s1_item.write_data);
                    PG_PRG1: n_prg_bank[1] = prg_bank_of(r_s1_item.write_data);
                    PG_PRG2: n_prg_bank[2] = prg_bank_of(r_s1_item.write_data);
                    PG_CHR:  n_chr_half = r_s1_item.write_data[0];
                    PG_IRQ_LO: n_irq_reload[7:0] = r_s1_item.write_data;
                    PG_IRQ_HI: n_irq_reload[15:8] = r_s1_item.write_data;
                    PG_IRQ_ACK: begin
                        n_irq_en      = {r_irq_en[0], r_irq_en[0]};
                        n_irq_pending = 1'b0;
                    end
                    PG_IRQ_CTL: begin
                        n_irq_en = r_s1_item.write_data[1:0];
                        if (r_s1_item.write_data[1]) begin
                            n_irq_count = r_irq_reload;
                        end
                        n_irq_pending = 1'b0;
                    end
                    PG_MIRROR: begin
                        n_mirror    = r_s1_item.write_data[1];
                        n_store_tgt = r_s1_item.write_data[0];
                    end
                    PG_XPOS: n_xpos = r_s1_item.write_data[2:0];
                    PG_XCOL: n_xcol = r_s1_item.write_data;
                    PG_XROW: n_xrow = r_s1_item.write_data;
                    default: ;
                endcase
            end
            CMD_CPU_READ: begin
                if (page == PG_XCOL) begin
                    n_out_item.read_data  = xl_lo;
                    n_out_item.read_valid = 1'b1;
                end else if (page == PG_XROW) begin
                    n_out_item.read_data  = xl_hi;
                    n_out_item.read_valid = 1'b1;
                end
            end
            CMD_CPU_MAP: begin
                if (r_s1_item.address[15:13] == 3'd3) begin
                    n_out_item.target = win[1] ? TGT_WRAM : TGT_BRAM;
                    n_out_item.target_address = {7'b0, win[0], r_s1_item.address[11:0]};
                end else if (r_s1_item.address[15] && (r_s1_item.address[14:13] != 2'd3)) begin
                    n_out_item.target = TGT_PRG;
                    n_out_item.target_address =
                        {r_prg_bank[r_s1_item.address[14:13]], r_s1_item.address[12:0]};
                end
            end
            CMD_CPU_TICK: begin
                if (r_irq_en[1]) begin
                    if (r_irq_count == 16'd0) begin
                        n_irq_pending = 1'b1;
                        n_irq_count   = r_irq_reload;
                    end else begin
                        n_irq_count = r_irq_count + 16'd1;
                    end
                end
            end
            CMD_NT_READ: begin
                // Attribute table reads leave the latched tile alone.
                if (r_s1_item.address[9:6] != 4'hF) begin
                    n_tile_value = mem_q;
                end
                n_out_item.target         = TGT_CIRAM;
                n_out_item.target_address = 20'(s1_idx);
            end
            CMD_NT_WRITE: begin
                n_out_item.target_address = 20'(s1_idx);
                n_out_item.target_write   = 1'b1;
                n_out_item.target         = r_store_tgt ? TGT_INTERNAL : TGT_CIRAM;
            end
            CMD_CHR_READ: begin
                if (r_s1_item.address[12]) begin
                    if (r_tile_value[6]) begin
                        if (r_s1_item.address[3]) begin
                            n_out_item.target    = TGT_CONST;
                            n_out_item.read_data = r_tile_value[7] ? 8'hFF : 8'h00;
                        end else begin
                            n_out_item.target = TGT_CHR_ROM;
                            n_out_item.target_address =
                                {2'b00, r_tile_value[5:0], r_s1_item.address[11:0]};
                        end
                    end else begin
                        n_out_item.target = TGT_CHR_RAM;
                        n_out_item.target_address =
                            {7'b0, r_tile_value[0], r_s1_item.address[11:0]};
                    end
                end else begin
                    n_out_item.target = TGT_CHR_RAM;
                    n_out_item.target_address = {7'b0, r_chr_half, r_s1_item.address[11:0]};
                end
            end
            CMD_UNUSED: ;
            default: ;
        endcase

        n_out_item.irq_line = n_irq_pending;
    end

    // Tile store port and bypass capture.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[s1_idx] <= r_s1_item.write_data;
        end
        if (in_acc) begin
            r_rd_data  <= mem[rd_idx];
            r_fwd      <= mem_we && (s1_idx == rd_idx);
            r_fwd_data <= r_s1_item.write_data;
        end
    end

    // Pipeline control, payload and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_tile_value  <= '0;
            r_irq_en      <= '0;
            r_irq_reload  <= '0;
            r_irq_count   <= '0;
            r_irq_pending <= 1'b0;
            r_prg_bank    <= '{default: '0};
            r_win_sel     <= '{default: '0};
            r_chr_half    <= 1'b0;
            r_mirror      <= 1'b0;
            r_store_tgt   <= 1'b0;
            r_xpos        <= '0;
            r_xcol        <= '0;
            r_xrow        <= '0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid   <= 1'b1;
                r_tile_value  <= n_tile_value;
                r_irq_en      <= n_irq_en;
                r_irq_reload  <= n_irq_reload;
                r_irq_count   <= n_irq_count;
                r_irq_pending <= n_irq_pending;
                r_prg_bank    <= n_prg_bank;
                r_win_sel     <= n_win_sel;
                r_chr_half    <= n_chr_half;
                r_mirror      <= n_mirror;
                r_store_tgt   <= n_store_tgt;
                r_xpos        <= n_xpos;
                r_xcol        <= n_xcol;
                r_xrow        <= n_xrow;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item <= i_in_item;
        end
        if (s1_adv) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // The input only stalls behind a full mapper stage and a held output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // Every item leaving the mapper stage shows up in the output register.
    a_stage_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> o_out_valid)
        else $error("mapper stage result lost");

    // The interrupt line only rises on a counter tick.
    a_irq_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_irq_pending) |-> $past(s1_adv && (s1_cmd == CMD_CPU_TICK)))
        else $error("interrupt raised without a tick");

endmodule
